### design/conv5x5_relu_maxpool_stream_assert.svh
// Assertion macros for the conv5x5_relu_maxpool_stream checker
`ifndef CONV5X5_RELU_MAXPOOL_STREAM_ASSERT_SVH
`define CONV5X5_RELU_MAXPOOL_STREAM_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define CRM_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Implication checked in the cycle after the antecedent.
`define CRM_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

### design/crm_pkg.sv
//------------------------------------------------------------------------------
// crm_pkg
// Shared constants and types of the convolution, ReLU and pooling stage.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package crm_pkg;
    localparam int IMAGE_SIDE  = 28;
    localparam int KERNEL_SIDE = 5;
    localparam int CHANNELS    = 30;
    localparam int POOL_SIDE   = 2;
    localparam int CONV_SIDE   = IMAGE_SIDE - KERNEL_SIDE + 1;
    localparam int POOL_OUT    = CONV_SIDE / POOL_SIDE;
    localparam int KAREA       = KERNEL_SIDE * KERNEL_SIDE;
    localparam int WCOUNT      = CHANNELS * KAREA;
    localparam int CH_W        = 5;
    localparam int COL_W       = 5;
    localparam int ACC_W       = 48;

    localparam logic [1:0] KIND_WEIGHT = 2'd0;
    localparam logic [1:0] KIND_BIAS   = 2'd1;
    localparam logic [1:0] KIND_PIXEL  = 2'd2;

    typedef logic [7:0] pix_t;
    typedef logic signed [15:0] wgt_t;

    // control passed from the sequencer into the cell chain
    typedef struct packed {
        logic            run;    // a channel's sum enters cell 0
        logic            pool;   // window position belongs to a pool cell
        logic            first;  // first position of a pool cell
        logic            done;   // last position of a pool cell
        logic [CH_W-1:0] ch;
        logic [3:0]      pr;
        logic [3:0]      pc;
    } cell_ctl_t;
endpackage
`default_nettype wire

### design/crm_mac_cell.sv
//------------------------------------------------------------------------------
// crm_mac_cell
// One multiply-accumulate cell of the kernel chain: adds pixel x weight to
// the partial sum handed in by its neighbor and registers it.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module crm_mac_cell (
    input  wire logic                             clk,
    input  wire logic                             en,
    input  wire logic [7:0]                       pix,
    input  wire logic signed [15:0]               wgt,
    input  wire logic signed [crm_pkg::ACC_W-1:0] sum_in,
    output logic signed [crm_pkg::ACC_W-1:0]      sum_out
);
    logic signed [crm_pkg::ACC_W-1:0] sum_reg;
    logic signed [24:0]               prod;

    assign prod = $signed({1'b0, pix}) * wgt;

    // hold the partial sum while the chain is stalled
    always_ff @(posedge clk)
    begin
        if (en)
            sum_reg <= sum_in + crm_pkg::ACC_W'(prod);
    end

    assign sum_out = sum_reg;
endmodule
`default_nettype wire

### design/conv5x5_relu_maxpool_stream.sv
//------------------------------------------------------------------------------
// conv5x5_relu_maxpool_stream
// 5x5 valid convolution, ReLU and 2x2 max pooling over a streamed frame.
//------------------------------------------------------------------------------
// channel | dir | fields
// s_axis  | in  | tuser=kind, tdata=slot,value
// m_axis  | out | tdata=channel,pool_row,pool_col,activation ; tlast=last
//
// A load item is stored on acceptance and leaves the input ready. A pixel item
// holds the input through the accept cycle, a run phase in which one channel a
// cycle enters the chain of 25 MAC cells from the weight memory read port, and
// a drain phase that empties the chain. Output stalls hold the chain and the
// input. Reset clears the window, line buffer, position and control; pool
// maxima need no clear (first position writes).
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module conv5x5_relu_maxpool_stream (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // slot[9:0], value[41:10], zero[47:42]
    input  wire logic [1:0]  s_axis_tuser,   // kind[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // channel, pool_row, pool_col, activation
    output logic             m_axis_tlast    // last
);
    localparam int K  = crm_pkg::KERNEL_SIDE;
    localparam int KA = crm_pkg::KAREA;
    localparam int AW = crm_pkg::ACC_W;
    localparam int CW = crm_pkg::CH_W;
    localparam int LAT = KA + 2;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN} state_t;
    state_t state_reg;

    logic [1:0]  kind;
    logic [9:0]  slot;
    logic signed [31:0] value;
    assign kind  = s_axis_tuser;
    assign slot  = s_axis_tdata[9:0];
    assign value = s_axis_tdata[41:10];

    // stores
    logic [KA*16-1:0]     wmem [crm_pkg::CHANNELS];
    logic signed [31:0]   bmem [crm_pkg::CHANNELS];
    logic [30:0]          pmem [crm_pkg::CHANNELS*crm_pkg::POOL_OUT];
    crm_pkg::pix_t        line_reg [K-1][crm_pkg::IMAGE_SIDE];
    crm_pkg::pix_t        win_reg  [K][K];
    logic [crm_pkg::COL_W-1:0] prow_reg, pcol_reg;

    logic [KA*16-1:0]   wrd_reg;
    logic signed [31:0] brd_reg;
    logic [CW-1:0]      ch_reg;
    logic [5:0]         drain_reg;
    crm_pkg::cell_ctl_t ctl_reg, ctl_d [KA];
    logic               stall;

    logic s_acc;
    assign s_axis_tready = (state_reg == S_IDLE) && !stall;
    assign s_acc = s_axis_tvalid && s_axis_tready;

    logic signed [15:0] wsat;
    assign wsat = (value > 32'sd32767) ? 16'sd32767 :
                  (value < -32'sd32768) ? -16'sd32768 : 16'(value);

    // slot / 25 by reciprocal multiply, exact for slots below 750
    logic [15:0] wq;
    logic [4:0]  wch;
    logic [4:0]  wpos;
    assign wq   = slot * 6'd41;
    assign wch  = 5'(wq >> 10);
    assign wpos = 5'(slot - 10'(wch) * 10'd25);

    always_ff @(posedge clk)
    begin
        if (s_acc && kind == crm_pkg::KIND_WEIGHT && slot < 10'(crm_pkg::WCOUNT))
        begin
            wmem[wch][wpos*16 +: 16] <= wsat;
        end
        if (s_acc && kind == crm_pkg::KIND_BIAS && slot < 10'(crm_pkg::CHANNELS))
        begin
            bmem[slot[CW-1:0]] <= value;
        end
        if (!stall)
        begin
            wrd_reg <= wmem[ch_reg];
            brd_reg <= bmem[ch_reg];
        end
    end

    // window and line buffer update; pool position
    logic [4:0] ci, cj;
    assign ci = prow_reg - 5'(K - 1);
    assign cj = pcol_reg - 5'(K - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            prow_reg  <= '0;
            pcol_reg  <= '0;
            ch_reg    <= '0;
            drain_reg <= '0;
            ctl_reg   <= '0;
            for (int r = 0; r < K; r++)
                for (int c = 0; c < K; c++)
                    win_reg[r][c] <= '0;
            for (int r = 0; r < K - 1; r++)
                for (int c = 0; c < crm_pkg::IMAGE_SIDE; c++)
                    line_reg[r][c] <= '0;
        end
        else if (!stall)
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    ctl_reg.run <= 1'b0;
                    if (s_acc && kind == crm_pkg::KIND_PIXEL)
                    begin
                        for (int r = 0; r < K; r++)
                            for (int c = 0; c < K - 1; c++)
                                win_reg[r][c] <= win_reg[r][c + 1];
                        for (int r = 0; r < K - 1; r++)
                            win_reg[r][K - 1] <= line_reg[r][pcol_reg];
                        win_reg[K - 1][K - 1] <= value[7:0];
                        for (int r = 0; r < K - 2; r++)
                            line_reg[r][pcol_reg] <= line_reg[r + 1][pcol_reg];
                        line_reg[K - 2][pcol_reg] <= value[7:0];
                        ctl_reg.pool <= prow_reg >= 5'(K - 1) && pcol_reg >= 5'(K - 1)
                            && ci < 5'(crm_pkg::POOL_OUT * 2)
                            && cj < 5'(crm_pkg::POOL_OUT * 2);
                        ctl_reg.first <= !ci[0] && !cj[0];
                        ctl_reg.done  <= ci[0] && cj[0];
                        ctl_reg.pr    <= ci[4:1];
                        ctl_reg.pc    <= cj[4:1];
                        if (pcol_reg == 5'(crm_pkg::IMAGE_SIDE - 1))
                        begin
                            pcol_reg <= '0;
                            prow_reg <= (prow_reg == 5'(crm_pkg::IMAGE_SIDE - 1)) ?
                                        '0 : prow_reg + 5'd1;
                        end
                        else
                        begin
                            pcol_reg <= pcol_reg + 5'd1;
                        end
                        ch_reg    <= '0;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    // reads for ch_reg land next cycle; tag that channel
                    ctl_reg.run <= 1'b1;
                    ctl_reg.ch  <= ch_reg;
                    if (ch_reg == CW'(crm_pkg::CHANNELS - 1))
                    begin
                        drain_reg <= '0;
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        ch_reg <= ch_reg + CW'(1);
                    end
                end
                S_DRAIN:
                begin
                    ctl_reg.run <= 1'b0;
                    drain_reg <= drain_reg + 6'd1;
                    if (drain_reg == 6'(LAT))
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    ctl_reg.run <= 1'b0;
                    state_reg   <= S_IDLE;
                end
            endcase
        end
    end

    // cell chain: cell i adds window[i] x weight[i]
    logic [KA*16-1:0]     wdl [KA-1];
    logic signed [AW-1:0] pipe_sum [KA];
    logic signed [24:0]   prod0;
    logic signed [AW-1:0] sum0_reg;

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            wdl[0] <= wrd_reg;
            for (int i = 1; i < KA - 1; i++)
                wdl[i] <= wdl[i - 1];
        end
    end

    assign prod0 = $signed({1'b0, win_reg[0][0]}) * $signed(wrd_reg[15:0]);

    always_ff @(posedge clk)
    begin
        if (!stall)
            sum0_reg <= AW'(brd_reg) + AW'(prod0);
    end
    assign pipe_sum[0] = sum0_reg;

    genvar g;
    generate
        for (g = 1; g < KA; g++)
        begin : g_cell
            crm_mac_cell u_cell (
                .clk     (clk),
                .en      (!stall),
                .pix     (win_reg[g / K][g % K]),
                .wgt     (wdl[g - 1][g*16 +: 16]),
                .sum_in  (pipe_sum[g - 1]),
                .sum_out (pipe_sum[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KA; i++)
                ctl_d[i] <= '0;
        end
        else if (!stall)
        begin
            ctl_d[0] <= ctl_reg;
            for (int i = 1; i < KA; i++)
                ctl_d[i] <= ctl_d[i - 1];
        end
    end

    // relu, saturate, pool
    crm_pkg::cell_ctl_t ce, cn;
    logic signed [AW-1:0] fin;
    logic [30:0] act, prev, mx;
    logic [30:0] prev_reg;
    logic [8:0]  paddr, raddr;
    assign ce   = ctl_d[KA - 1];
    assign cn   = ctl_d[KA - 2];
    assign fin  = pipe_sum[KA - 1];
    assign act  = fin < 0 ? 31'd0 : (fin > AW'(32'h7FFFFFFF) ? 31'h7FFFFFFF : fin[30:0]);
    assign paddr = 9'(ce.ch * crm_pkg::POOL_OUT + ce.pc);
    // read one stage early so the running maximum comes from a register
    assign raddr = 9'(cn.ch * crm_pkg::POOL_OUT + cn.pc);
    assign prev = prev_reg;
    assign mx   = (ce.first || act > prev) ? act : prev;

    logic        ov_reg;
    logic [47:0] od_reg;
    logic        ol_reg;
    assign stall = ov_reg && !m_axis_tready;

    always_ff @(posedge clk)
    begin
        if (!stall && ce.run && ce.pool)
            pmem[paddr] <= mx;
        if (!stall)
        begin
            prev_reg <= pmem[raddr];
            od_reg <= {4'd0, mx, ce.pc, ce.pr, ce.ch};
            ol_reg <= ce.ch == CW'(crm_pkg::CHANNELS - 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (!stall)
            ov_reg <= ce.run && ce.pool && ce.done;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tlast  = ol_reg;
endmodule
`default_nettype wire

### design/crm_checker.sv
//------------------------------------------------------------------------------
// crm_checker
// Port-level checks of the convolution stage, bound to the top level.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "conv5x5_relu_maxpool_stream_assert.svh"
module crm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);
    logic       m_wait;
    logic [4:0] m_ch;
    assign m_wait = m_axis_tvalid && !m_axis_tready;
    assign m_ch   = m_axis_tdata[4:0];

    `CRM_ASSERT_NEXT(a_hold, clk, rst_n, m_wait, m_axis_tvalid && $stable(m_axis_tdata))
    `CRM_ASSERT_IMPL(a_chan, clk, rst_n, m_axis_tvalid, m_ch < 5'd30)
    `CRM_ASSERT_IMPL(a_last, clk, rst_n, m_axis_tvalid, m_axis_tlast == (m_ch == 5'd29))
    `CRM_ASSERT_IMPL(a_pos, clk, rst_n, m_axis_tvalid, m_axis_tdata[8:5] < 4'd12 && m_axis_tdata[12:9] < 4'd12)
    `CRM_ASSERT_IMPL(a_block, clk, rst_n, m_wait, !s_axis_tready)
endmodule
bind conv5x5_relu_maxpool_stream crm_checker u_crm_checker (.*);
`default_nettype wire

### dv/tb_top.sv
//------------------------------------------------------------------------------
// tb_top
// Stream-level test of the 5x5 convolution, ReLU and 2x2 max pooling stage.
// Loads the weight and bias stores in full, then streams pixels, and
// checks every pooled value against a built-in model of the stage.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
    localparam int  IMAGE_SIDE  = crm_pkg::IMAGE_SIDE;
    localparam int  KERNEL_SIDE = crm_pkg::KERNEL_SIDE;
    localparam int  CHANNELS    = crm_pkg::CHANNELS;
    localparam int  POOL_SIDE   = crm_pkg::POOL_SIDE;
    localparam int  POOL_OUT    = crm_pkg::POOL_OUT;
    localparam int  KAREA       = crm_pkg::KAREA;
    localparam int  WCOUNT      = crm_pkg::WCOUNT;
    localparam logic [1:0] KIND_WEIGHT = crm_pkg::KIND_WEIGHT;
    localparam logic [1:0] KIND_BIAS   = crm_pkg::KIND_BIAS;
    localparam logic [1:0] KIND_PIXEL  = crm_pkg::KIND_PIXEL;

    localparam int  CYCLE_LIMIT = 3000000;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  kind;
        logic [9:0]  slot;
        logic [31:0] value;
    } load_item_t;

    typedef struct {
        logic [4:0]  ch;
        logic [3:0]  pr;
        logic [3:0]  pc;
        logic [30:0] act;
        logic        last;
    } pooled_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;

    conv5x5_relu_maxpool_stream u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // slot[9:0], value[41:10], zero[47:42]
        .s_axis_tuser  (s_axis_tuser),   // kind[1:0]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // channel, pool_row, pool_col, activation
        .m_axis_tlast  (m_axis_tlast)    // last
    );

    // model state
    logic signed [15:0] weight_mem [WCOUNT];
    logic signed [31:0] bias_mem [CHANNELS];
    logic [7:0]         line_buf [KERNEL_SIDE-1][IMAGE_SIDE];
    logic [7:0]         window [KERNEL_SIDE][KERNEL_SIDE];
    logic [30:0]        pool_max [CHANNELS][POOL_OUT];
    int                 pix_row;
    int                 pix_col;

    load_item_t pending_items[$];
    pooled_t    pooled_expected[$];
    int         tx_idle;
    int         rx_idle;
    int         errors;
    int         cycles;
    int         items_sent;
    int         results_seen;
    logic       in_fire;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [30:0] conv_relu(int ch);
        longint acc;
        acc = longint'(bias_mem[ch]);
        for (int r = 0; r < KERNEL_SIDE; r++)
            for (int c = 0; c < KERNEL_SIDE; c++)
                acc += longint'({1'b0, window[r][c]}) *
                       longint'(weight_mem[ch*KAREA + r*KERNEL_SIDE + c]);
        if (acc < 0)
            acc = 0;
        if (acc > 64'sh7FFFFFFF)
            acc = 64'sh7FFFFFFF;
        return acc[30:0];
    endfunction

    task automatic predict_item(load_item_t it);
        longint     v;
        logic [7:0] px;
        int         ci;
        int         cj;
        logic       first;
        logic       done;
        logic [30:0] a;
        pooled_t    res;
        v = longint'($signed(it.value));
        if (it.kind == KIND_WEIGHT)
        begin
            if (it.slot < WCOUNT)
            begin
                if (v > 32767)
                    v = 32767;
                if (v < -32768)
                    v = -32768;
                weight_mem[it.slot] = v[15:0];
            end
        end
        else if (it.kind == KIND_BIAS)
        begin
            if (it.slot < CHANNELS)
                bias_mem[it.slot] = it.value;
        end
        else if (it.kind == KIND_PIXEL)
        begin
            px = it.value[7:0];
            for (int r = 0; r < KERNEL_SIDE; r++)
                for (int c = 0; c + 1 < KERNEL_SIDE; c++)
                    window[r][c] = window[r][c+1];
            for (int r = 0; r + 1 < KERNEL_SIDE; r++)
                window[r][KERNEL_SIDE-1] = line_buf[r][pix_col];
            window[KERNEL_SIDE-1][KERNEL_SIDE-1] = px;
            for (int r = 0; r + 2 < KERNEL_SIDE; r++)
                line_buf[r][pix_col] = line_buf[r+1][pix_col];
            line_buf[KERNEL_SIDE-2][pix_col] = px;

            ci = pix_row - (KERNEL_SIDE - 1);
            cj = pix_col - (KERNEL_SIDE - 1);
            // positions past the last whole pool cell are skipped; 24 conv rows and columns leave none
            if (ci >= 0 && cj >= 0 && ci < POOL_OUT*POOL_SIDE && cj < POOL_OUT*POOL_SIDE)
            begin
                first = (ci % POOL_SIDE == 0) && (cj % POOL_SIDE == 0);
                done  = (ci % POOL_SIDE == POOL_SIDE-1) && (cj % POOL_SIDE == POOL_SIDE-1);
                for (int ch = 0; ch < CHANNELS; ch++)
                begin
                    a = conv_relu(ch);
                    if (first || a > pool_max[ch][cj/POOL_SIDE])
                        pool_max[ch][cj/POOL_SIDE] = a;
                end
                if (done)
                    for (int ch = 0; ch < CHANNELS; ch++)
                    begin
                        res.ch   = ch[4:0];
                        res.pr   = 4'(ci / POOL_SIDE);
                        res.pc   = 4'(cj / POOL_SIDE);
                        res.act  = pool_max[ch][cj/POOL_SIDE];
                        res.last = (ch == CHANNELS-1);
                        pooled_expected.push_back(res);
                    end
            end
            pix_col++;
            if (pix_col >= IMAGE_SIDE)
            begin
                pix_col = 0;
                pix_row++;
                if (pix_row >= IMAGE_SIDE)
                    pix_row = 0;
            end
        end
    endtask

    task automatic push_item(logic [1:0] kind, logic [9:0] slot, logic [31:0] value);
        load_item_t it;
        it.kind  = kind;
        it.slot  = slot;
        it.value = value;
        pending_items.push_back(it);
    endtask

    // wide: full 32-bit values that mostly saturate; otherwise Q3.12 in a modest range
    task automatic load_stores(bit wide);
        logic [31:0] v;
        for (int i = 0; i < WCOUNT; i++)
        begin
            if (wide)
                v = $urandom();
            else
                v = 32'($signed($urandom_range(4000)) - 2000);
            push_item(KIND_WEIGHT, 10'(i), v);
        end
        for (int i = 0; i < CHANNELS; i++)
        begin
            case ($urandom_range(3))
                0: v = 32'h7FFF_FFFF;
                1: v = 32'h8000_0000;
                default: v = 32'($signed($urandom_range(32'h0100_0000)) - 32'sh0080_0000);
            endcase
            push_item(KIND_BIAS, 10'(i), v);
        end
    endtask

    task automatic push_pixels(int count);
        logic [31:0] v;
        for (int i = 0; i < count; i++)
        begin
            v = $urandom();
            case ($urandom_range(9))
                0: v[7:0] = 8'h00;
                1: v[7:0] = 8'hFF;
                default: ;
            endcase
            push_item(KIND_PIXEL, 10'($urandom()), v);
            // ignored noise between pixels
            if ($urandom_range(19) == 0)
                push_item(KIND_UNUSED, 10'($urandom()), $urandom());
        end
    endtask

    task automatic drain_all();
        while (pending_items.size() != 0 || s_axis_tvalid || pooled_expected.size() != 0)
            @(posedge clk);
        // a pixel with no result may still be in the MAC chain
        repeat (3 * CHANNELS) @(posedge clk);
    endtask

    // sender
    always @(negedge clk)
    begin
        if (!s_axis_tvalid || in_fire)
        begin
            if (rst_n && pending_items.size() != 0 && $urandom_range(99) >= tx_idle)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= pending_items[0].kind;
                s_axis_tdata  <= {6'd0, pending_items[0].value, pending_items[0].slot};
                void'(pending_items.pop_front());
            end
            else
                s_axis_tvalid <= 1'b0;
        end
        m_axis_tready <= rst_n && ($urandom_range(99) >= rx_idle);
    end

    // input acceptance and prediction
    always @(posedge clk)
    begin
        load_item_t it;
        in_fire <= s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            it.kind  = s_axis_tuser;
            it.slot  = s_axis_tdata[9:0];
            it.value = s_axis_tdata[41:10];
            predict_item(it);
            items_sent++;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        pooled_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (pooled_expected.size() == 0)
            begin
                $error("unexpected pooled value: tdata=%h", m_axis_tdata);
                errors++;
            end
            else
            begin
                exp_r = pooled_expected.pop_front();
                if (m_axis_tdata[4:0] != exp_r.ch)
                begin
                    $error("channel: expected %0d, got %0d", exp_r.ch, m_axis_tdata[4:0]);
                    errors++;
                end
                if (m_axis_tdata[8:5] != exp_r.pr)
                begin
                    $error("pool_row: expected %0d, got %0d", exp_r.pr, m_axis_tdata[8:5]);
                    errors++;
                end
                if (m_axis_tdata[12:9] != exp_r.pc)
                begin
                    $error("pool_col: expected %0d, got %0d", exp_r.pc, m_axis_tdata[12:9]);
                    errors++;
                end
                if (m_axis_tdata[43:13] != exp_r.act)
                begin
                    $error("activation: expected %0d, got %0d", exp_r.act,
                           m_axis_tdata[43:13]);
                    errors++;
                end
                if (m_axis_tlast != exp_r.last)
                begin
                    $error("last: expected %0d, got %0d", exp_r.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_WEIGHT;
        m_axis_tready = 1'b0;
        in_fire       = 1'b0;
        errors        = 0;
        cycles        = 0;
        items_sent    = 0;
        results_seen  = 0;
        pix_row       = 0;
        pix_col       = 0;
        foreach (weight_mem[i]) weight_mem[i] = '0;
        foreach (bias_mem[i]) bias_mem[i] = '0;
        foreach (line_buf[r, c]) line_buf[r][c] = '0;
        foreach (window[r, c]) window[r][c] = '0;
        foreach (pool_max[r, c]) pool_max[r][c] = '0;
        tx_idle = 31;
        rx_idle = 80;
        rst_n   = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: ignored kind, out-of-range slots, weight saturation
        push_item(KIND_UNUSED, 10'd0, 32'h0000_00FF);
        push_item(KIND_WEIGHT, 10'(WCOUNT), 32'h0000_1234);
        push_item(KIND_WEIGHT, 10'h3FF, 32'hFFFF_FFFF);
        push_item(KIND_BIAS, 10'(CHANNELS), 32'h7FFF_FFFF);
        push_item(KIND_BIAS, 10'h3FF, 32'h8000_0000);
        load_stores(1'b0);
        push_item(KIND_WEIGHT, 10'd0, 32'h7FFF_FFFF);
        push_item(KIND_WEIGHT, 10'd1, 32'h8000_0000);
        push_item(KIND_WEIGHT, 10'd2, 32'd40000);
        push_item(KIND_WEIGHT, 10'(WCOUNT-1), 32'hFFFF_8000);
        push_item(KIND_WEIGHT, 10'd3, 32'h0000_7FFF);
        push_item(KIND_BIAS, 10'd0, 32'h7FFF_FFFF);
        push_item(KIND_BIAS, 10'(CHANNELS-1), 32'h8000_0000);
        push_pixels(170);
        drain_all();

        tx_idle = 80;
        rx_idle = 31;
        push_pixels(70);
        drain_all();

        tx_idle = 0;
        rx_idle = 0;
        push_pixels(70);
        drain_all();

        $display("%0d input items accepted, %0d pooled values checked over three pool rows",
                 items_sent, results_seen);
        $display("stores loaded in full, saturating weights and extreme biases included");
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

### sim.f
+incdir+design
design/crm_pkg.sv
design/crm_mac_cell.sv
design/conv5x5_relu_maxpool_stream.sv
design/crm_checker.sv
dv/tb_top.sv
